@@ src/genome_interaction_scorer_defines.svh @@
// assertion macros for the genome interaction scorer
// included by the top level, no other dependencies
`ifndef GENOME_INTERACTION_SCORER_DEFINES_SVH
`define GENOME_INTERACTION_SCORER_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define GIS_ASSERT_IMPL(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("scorer check failed");

// condition holds in the cycle after the trigger
`define GIS_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("scorer check failed");

`endif

@@ src/gis_pkg.sv @@
// shared types, codes and constants of the genome interaction scorer
// no dependencies
package gis_pkg;

  localparam int TABLE_SIDE  = 256;
  localparam int TBL_ADDR_W  = 16;
  localparam int WORD_TARGET = 12;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;
  localparam logic [23:0] RESULT_MAX = 24'hFFFFFF;

  localparam logic [1:0] KIND_TABLE  = 2'd0;
  localparam logic [1:0] KIND_FIT    = 2'd1;
  localparam logic [1:0] KIND_ENERGY = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_USE_BLOCKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DELTA  = 1'd1;

  typedef struct packed {
    logic                  wr_en;
    logic [TBL_ADDR_W-1:0] wr_addr;
    logic [7:0]            wr_value;
    logic [TBL_ADDR_W-1:0] rd_addr;
  } tbl_req_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, v[i]};
    end
    return n;
  endfunction

endpackage

@@ src/gis_score_table.sv @@
// interaction score table: one write port, one registered read port
// depends on gis_pkg
module gis_score_table #(
  parameter int ENTRY_WIDTH = 8
) (
  input  logic                   clk,
  input  gis_pkg::tbl_req_t      req,
  output logic [ENTRY_WIDTH-1:0] rd_data
);

  logic [ENTRY_WIDTH-1:0] mem [gis_pkg::TABLE_SIDE * gis_pkg::TABLE_SIDE];
  logic [15:0]            value_ext;

  assign value_ext = {{8{req.wr_value[7]}}, req.wr_value};

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= value_ext[ENTRY_WIDTH-1:0];
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

@@ src/gis_divider.sv @@
// restoring divider, one quotient bit per cycle
// no dependencies
module gis_divider #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial    = {rem, quo[NUM_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
        rem   <= '0;
        den   <= divisor;
        quo   <= dividend;
      end else if (busy) begin
        rem   <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        quo   <= {quo[NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/genome_interaction_scorer.sv @@
// Genome interaction scorer. Each word pair passes through the accept in S_IDLE, four byte steps
// through the shared accumulator (one table read port, one lookup per byte) and a closing add.
// A word pair beyond MAX_WORDS adds nothing to the sum, and a table write leaves the block in
// S_IDLE. The last word of a run then passes through S_FINISH and S_OUT, and waits in S_OUT while
// an earlier result is still stalled. An energy run whose folded score passes min_delta also runs
// a multiply, a divider start and the restoring divider, one quotient bit per cycle over
// 16 + ceil(log2(12*MAX_WORDS+1)) bits, before its result reaches S_OUT.
// The block takes no item while it works on one.
// depends on gis_pkg, gis_score_table, gis_divider and genome_interaction_scorer_defines.svh
`include "genome_interaction_scorer_defines.svh"

module genome_interaction_scorer #(
  parameter int MAX_WORDS   = 8,
  parameter int ENTRY_WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gis_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gis_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       kind,
  input  logic [31:0]                      own_word,
  input  logic [31:0]                      target_word,
  input  logic                             last_word,
  input  logic [15:0]                      start_fitness,
  input  logic [15:0]                      target_energy,
  input  logic [7:0]                       table_row,
  input  logic [7:0]                       table_col,
  input  logic signed [7:0]                table_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [23:0]                      result_value,
  output logic                             result_kind
);

  localparam int WC_W  = $clog2(MAX_WORDS + 1);
  localparam int P_W   = $clog2(gis_pkg::WORD_TARGET * MAX_WORDS + 1);
  localparam int NUM_W = P_W + 16;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_STEP   = 8'b0000_0010,
    S_TAIL   = 8'b0000_0100,
    S_FINISH = 8'b0000_1000,
    S_MUL    = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t            state;
  logic              use_blocks;
  logic [9:0]        min_delta;
  logic [31:0]       running_sum;
  logic [WC_W-1:0]   word_counter;
  logic [15:0]       held_energy;
  logic [1:0]        kind_q;
  logic [31:0]       own_q;
  logic [31:0]       tgt_q;
  logic              last_q;
  logic [1:0]        step;
  logic [P_W-1:0]    folded_q;
  logic [P_W-1:0]    p_q;
  logic [NUM_W-1:0]  prod_q;
  logic [23:0]       res_q;

  logic                   in_accept;
  logic                   out_free;
  gis_pkg::tbl_req_t      tbl_req;
  logic [ENTRY_WIDTH-1:0] tbl_data;
  logic                   div_start;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quo;
  logic [1:0]             add_sel;
  logic [31:0]            rr_word;
  logic [31:0]            rl_word;
  logic [3:0]             pc_rr;
  logic [3:0]             pc_rl;
  logic [31:0]            term;
  logic [P_W-1:0]         p_val;
  logic signed [31:0]     diff;
  logic signed [31:0]     abs_diff;
  logic signed [31:0]     folded;
  logic                   energy_hit;
  logic signed [31:0]     sum_s;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_DSTART);

  assign tbl_req.wr_en    = in_accept && (kind == gis_pkg::KIND_TABLE);
  assign tbl_req.wr_addr  = {table_row, table_col};
  assign tbl_req.wr_value = table_value;
  assign tbl_req.rd_addr  = {own_q[step*8 +: 8], tgt_q[step*8 +: 8]};

  // byte term of the shared accumulator
  assign add_sel = (state == S_TAIL) ? 2'd3 : step - 2'd1;
  assign rr_word = {own_q[0], own_q[31:1]};
  assign rl_word = {own_q[30:0], own_q[31]};
  assign pc_rr   = gis_pkg::popcount8(rr_word[add_sel*8 +: 8] ^ tgt_q[add_sel*8 +: 8]);
  assign pc_rl   = gis_pkg::popcount8(rl_word[add_sel*8 +: 8] ^ tgt_q[add_sel*8 +: 8]);

  always_comb begin
    if (use_blocks) begin
      term = {{(32-ENTRY_WIDTH){tbl_data[ENTRY_WIDTH-1]}}, tbl_data};
    end else begin
      term = {28'd0, pc_rr} - {28'd0, pc_rl};
    end
  end

  // energy fold
  assign p_val      = P_W'(word_counter * gis_pkg::WORD_TARGET);
  assign sum_s      = running_sum;
  assign diff       = $signed({{(32-P_W){1'b0}}, p_val}) - sum_s;
  assign abs_diff   = diff[31] ? -diff : diff;
  assign folded     = $signed({{(32-P_W){1'b0}}, p_val}) - abs_diff;
  assign energy_hit = (folded > $signed({22'd0, min_delta})) && (p_val != '0);

  gis_score_table #(
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_table (
    .clk    (clk),
    .req    (tbl_req),
    .rd_data(tbl_data)
  );

  gis_divider #(
    .NUM_W(NUM_W),
    .DEN_W(P_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod_q),
    .divisor (p_q),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      use_blocks <= 1'b0;
      min_delta  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gis_pkg::REG_USE_BLOCKS: use_blocks <= cfg_data[0];
        gis_pkg::REG_MIN_DELTA:  min_delta  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_sum  <= '0;
      word_counter <= '0;
      held_energy  <= '0;
      step         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && (kind == gis_pkg::KIND_FIT || kind == gis_pkg::KIND_ENERGY)) begin
            kind_q <= kind;
            own_q  <= own_word;
            tgt_q  <= target_word;
            last_q <= last_word;
            if (word_counter == '0) begin
              running_sum <= (kind == gis_pkg::KIND_FIT) ? {16'd0, start_fitness} : 32'd0;
              held_energy <= target_energy;
            end
            if (word_counter < WC_W'(MAX_WORDS)) begin
              word_counter <= word_counter + 1'b1;
              step         <= '0;
              state        <= S_STEP;
            end else if (last_word) begin
              state <= S_FINISH;
            end
          end
        end
        S_STEP: begin
          if (step != 2'd0) begin
            running_sum <= running_sum + term;
          end
          step <= step + 1'b1;
          if (step == 2'd3) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          running_sum <= running_sum + term;
          state       <= last_q ? S_FINISH : S_IDLE;
        end
        S_FINISH: begin
          folded_q <= folded[P_W-1:0];
          p_q      <= p_val;
          if (kind_q == gis_pkg::KIND_FIT) begin
            if (sum_s < 0) begin
              res_q <= '0;
            end else if (sum_s > $signed({8'd0, gis_pkg::RESULT_MAX})) begin
              res_q <= gis_pkg::RESULT_MAX;
            end else begin
              res_q <= running_sum[23:0];
            end
            state <= S_OUT;
          end else if (energy_hit) begin
            state <= S_MUL;
          end else begin
            res_q <= '0;
            state <= S_OUT;
          end
        end
        S_MUL: begin
          prod_q <= NUM_W'(folded_q) * NUM_W'(held_energy);
          state  <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_q <= 24'(div_quo);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            result_value <= res_q;
            result_kind  <= (kind_q == gis_pkg::KIND_ENERGY);
            running_sum  <= '0;
            word_counter <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GIS_ASSERT_IMPL(a_wc_range, clk, rst, 1'b1, word_counter <= WC_W'(MAX_WORDS))
  `GIS_ASSERT_IMPL(a_div_done_state, clk, rst, div_done, state == S_DIV)
  `GIS_ASSERT_NEXT(a_out_load, clk, rst, state == S_OUT && out_free, out_valid && word_counter == '0 && state == S_IDLE)

endmodule
